// ===== src/segtr_pkg.sv =====
// segtr_pkg: shared types, codes and constants of the segment tree range sum block
// transaction payload structs, engine state type and node evaluation flags
// no dependencies
package segtr_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int INDEX_W          = 10;
   localparam int BOUND_W          = 11;
   localparam int VALUE_W          = 32;
   localparam int COUNT_W          = 11;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   localparam logic ACTION_UPDATE = 1'b0;
   localparam logic ACTION_QUERY  = 1'b1;

   typedef struct packed {
      logic                       action;
      logic [INDEX_W-1:0]         element_index;
      logic signed [VALUE_W-1:0]  elem_value;
      logic [BOUND_W-1:0]         range_first;
      logic [BOUND_W-1:0]         range_end;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  range_sum;
      logic                       index_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ELEM,
      ST_DELTA,
      ST_NREAD,
      ST_NWRITE,
      ST_QWALK,
      ST_QLAST,
      ST_DONE
   } engine_state_type;

   typedef struct packed {
      logic disjoint;
      logic covered;
      logic leaf;
      logic go_left;
   } node_flags_type;

endpackage

// ===== src/segtr_node_eval.sv =====
// segtr_node_eval: range split and classification of one tree node
// computes the floor midpoint and coverage flags; uses segtr_pkg
module segtr_node_eval #(
   parameter int LW = 11
) (
   input  logic [LW-1:0]            lo,
   input  logic [LW-1:0]            hi,
   input  logic [LW-1:0]            ql,
   input  logic [LW-1:0]            qr,
   input  logic [LW-1:0]            idx,
   output logic [LW-1:0]            mid,
   output segtr_pkg::node_flags_type flags
);

   logic [LW:0] span_sum;

   assign span_sum = {1'b0, lo} + {1'b0, hi};
   assign mid      = span_sum[LW:1];

   always_comb begin
      flags.disjoint = (ql >= hi) || (qr <= lo);
      flags.covered  = (ql <= lo) && (qr >= hi);
      flags.leaf     = (hi - lo) < LW'(2);
      flags.go_left  = idx < mid;
   end

endmodule

// ===== src/segtr_engine.sv =====
// segtr_engine: node and element stores with the update and query walks
// holds both memories, the clearing sweep and the depth-first query stack
// depends on segtr_pkg and segtr_node_eval
module segtr_engine #(
   parameter int MAX_ELEMENTS = segtr_pkg::MAX_ELEMENTS_DEF,
   parameter int LW           = ($clog2(MAX_ELEMENTS + 1) > segtr_pkg::BOUND_W) ?
                                $clog2(MAX_ELEMENTS + 1) : segtr_pkg::BOUND_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               clear_req,
   input  logic [LW-1:0]      used_count,
   input  logic               start,
   input  segtr_pkg::req_type req,
   output logic               busy,
   output logic               done,
   output segtr_pkg::rsp_type rsp
);

   localparam int NAW        = $clog2(MAX_ELEMENTS) + 1;
   localparam int NODE_DEPTH = 1 << NAW;
   localparam int EAW        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int STK_DEPTH  = NAW;
   localparam int SPW        = $clog2(STK_DEPTH + 1);
   localparam int SAW        = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
   localparam int VW         = segtr_pkg::VALUE_W;

   segtr_pkg::engine_state_type state_ff, state_in;
   segtr_pkg::req_type          req_ff, req_in;
   logic [NAW-1:0]  clr_ff, clr_in;
   logic [NAW-1:0]  node_ff, node_in;
   logic [LW-1:0]   lo_ff, lo_in;
   logic [LW-1:0]   hi_ff, hi_in;
   logic [SPW-1:0]  sp_ff, sp_in;
   logic [SPW-1:0]  sp_top;
   logic [VW-1:0]   delta_ff, delta_in;
   logic [VW-1:0]   acc_ff, acc_in;
   logic            pend_ff, pend_in;
   logic            err_ff, err_in;

   logic [VW-1:0]   node_mem [NODE_DEPTH];
   logic [VW-1:0]   elem_mem [MAX_ELEMENTS];
   logic [VW-1:0]   node_rd_ff;
   logic [VW-1:0]   elem_rd_ff;
   logic            node_we, elem_we;
   logic [NAW-1:0]  node_wa, node_ra;
   logic [VW-1:0]   node_wd, elem_wd;
   logic [EAW-1:0]  elem_wa, elem_ra;

   logic [NAW-1:0]  stk_node [STK_DEPTH];
   logic [LW-1:0]   stk_lo   [STK_DEPTH];
   logic [LW-1:0]   stk_hi   [STK_DEPTH];
   logic            push;

   logic [LW-1:0]   idx_x, ql_x, qr_x, mid;
   logic [NAW-1:0]  left_node, right_node;
   segtr_pkg::node_flags_type flags;

   assign idx_x      = LW'(req_ff.element_index);
   assign ql_x       = LW'(req_ff.range_first);
   assign qr_x       = LW'(req_ff.range_end);
   assign left_node  = node_ff << 1;
   assign right_node = (node_ff << 1) | NAW'(1);
   assign sp_top     = sp_ff - SPW'(1);

   segtr_node_eval #(
      .LW (LW)
   ) u_eval (
      .lo    (lo_ff),
      .hi    (hi_ff),
      .ql    (ql_x),
      .qr    (qr_x),
      .idx   (idx_x),
      .mid   (mid),
      .flags (flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= segtr_pkg::ST_CLEAR;
         clr_ff   <= '0;
         sp_ff    <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sp_ff    <= sp_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      node_ff  <= node_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      delta_ff <= delta_in;
      acc_ff   <= acc_in;
      err_ff   <= err_in;
   end

   // stores: one write and one registered read each per cycle
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      node_rd_ff <= node_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_wa] <= elem_wd;
      end
      elem_rd_ff <= elem_mem[elem_ra];
   end

   // deferred right children of partly covered nodes
   always_ff @(posedge clock) begin
      if (push) begin
         stk_node[sp_ff[SAW-1:0]] <= right_node;
         stk_lo[sp_ff[SAW-1:0]]   <= mid;
         stk_hi[sp_ff[SAW-1:0]]   <= hi_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      clr_in   = clr_ff;
      node_in  = node_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      sp_in    = sp_ff;
      delta_in = delta_ff;
      acc_in   = acc_ff;
      pend_in  = 1'b0;
      err_in   = err_ff;
      node_we  = 1'b0;
      node_wa  = node_ff;
      node_wd  = node_rd_ff + delta_ff;
      node_ra  = node_ff;
      elem_we  = 1'b0;
      elem_wa  = idx_x[EAW-1:0];
      elem_wd  = req_ff.elem_value;
      elem_ra  = idx_x[EAW-1:0];
      push     = 1'b0;
      done     = 1'b0;
      busy     = (state_ff != segtr_pkg::ST_IDLE);

      // read data of a covered node lands in the cycle after its address
      if (pend_ff) begin
         acc_in = acc_ff + node_rd_ff;
      end

      case (state_ff)
         segtr_pkg::ST_CLEAR: begin
            node_we = 1'b1;
            node_wa = clr_ff;
            node_wd = '0;
            elem_we = (32'(clr_ff) < MAX_ELEMENTS);
            elem_wa = clr_ff[EAW-1:0];
            elem_wd = '0;
            clr_in  = clr_ff + NAW'(1);
            if (clr_ff == {NAW{1'b1}}) begin
               state_in = segtr_pkg::ST_IDLE;
            end
         end
         segtr_pkg::ST_IDLE: begin
            if (start) begin
               req_in  = req;
               acc_in  = '0;
               err_in  = 1'b0;
               node_in = NAW'(1);
               lo_in   = '0;
               hi_in   = used_count;
               sp_in   = '0;
               if (req.action == segtr_pkg::ACTION_QUERY) begin
                  state_in = segtr_pkg::ST_QWALK;
               end else if (LW'(req.element_index) >= used_count) begin
                  err_in   = 1'b1;
                  state_in = segtr_pkg::ST_DONE;
               end else begin
                  state_in = segtr_pkg::ST_ELEM;
               end
            end
         end
         segtr_pkg::ST_ELEM: begin
            state_in = segtr_pkg::ST_DELTA;
         end
         segtr_pkg::ST_DELTA: begin
            delta_in = VW'(req_ff.elem_value) - elem_rd_ff;
            elem_we  = 1'b1;
            state_in = segtr_pkg::ST_NREAD;
         end
         segtr_pkg::ST_NREAD: begin
            state_in = segtr_pkg::ST_NWRITE;
         end
         segtr_pkg::ST_NWRITE: begin
            node_we = 1'b1;
            if (flags.leaf) begin
               state_in = segtr_pkg::ST_DONE;
            end else begin
               state_in = segtr_pkg::ST_NREAD;
               if (flags.go_left) begin
                  node_in = left_node;
                  hi_in   = mid;
               end else begin
                  node_in = right_node;
                  lo_in   = mid;
               end
            end
         end
         segtr_pkg::ST_QWALK: begin
            if (flags.disjoint || flags.covered) begin
               pend_in = ~flags.disjoint;
               if (sp_ff == '0) begin
                  state_in = segtr_pkg::ST_QLAST;
               end else begin
                  node_in = stk_node[sp_top[SAW-1:0]];
                  lo_in   = stk_lo[sp_top[SAW-1:0]];
                  hi_in   = stk_hi[sp_top[SAW-1:0]];
                  sp_in   = sp_top;
               end
            end else begin
               push    = 1'b1;
               sp_in   = sp_ff + SPW'(1);
               node_in = left_node;
               hi_in   = mid;
            end
         end
         segtr_pkg::ST_QLAST: begin
            state_in = segtr_pkg::ST_DONE;
         end
         segtr_pkg::ST_DONE: begin
            done     = 1'b1;
            state_in = segtr_pkg::ST_IDLE;
         end
         default: begin
            state_in = segtr_pkg::ST_IDLE;
         end
      endcase

      // a new element count reshapes the tree: sweep both stores again
      if (clear_req) begin
         state_in = segtr_pkg::ST_CLEAR;
         clr_in   = '0;
         pend_in  = 1'b0;
      end
   end

   always_comb begin
      rsp.range_sum   = acc_ff;
      rsp.index_error = err_ff;
   end

endmodule

// ===== src/segment_tree_range_sum.sv =====
// segment_tree_range_sum: top level with element count register and result register
// depends on segtr_pkg and segtr_engine
//
// One transaction per operation: an update sets one element, a query returns the wrapping
// 32-bit sum over [range_first, range_end). After reset, and after every write of the
// element count, both stores are swept to zero over every node address with busy high;
// the write itself always takes effect at once. An update holds busy while it reads the
// old element, writes the new one and then does a read-modify-write of the node store
// on each tree level on its path (eleven at 1024 elements). A query holds busy while
// its depth-first walk visits its nodes, one node per cycle through the single read
// port of the node store. An update at or beyond the element count skips the walk and
// sets index_error. Each result is shown for exactly one cycle on rsp_valid and must
// be captured then: there is no back-pressure on the result side. A new start is taken
// the cycle the result shows.
module segment_tree_range_sum #(
   parameter int MAX_ELEMENTS = segtr_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  segtr_pkg::req_type                  req_payload,
   output logic                                rsp_valid,
   output segtr_pkg::rsp_type                  rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [segtr_pkg::COUNT_W-1:0]       csr_wr_data
);

   localparam int LW = ($clog2(MAX_ELEMENTS + 1) > segtr_pkg::BOUND_W) ?
                       $clog2(MAX_ELEMENTS + 1) : segtr_pkg::BOUND_W;

   logic [segtr_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [LW-1:0]                 count_x;
   logic [LW-1:0]                 used_count;
   logic                          rsp_valid_ff, rsp_valid_in;
   segtr_pkg::rsp_type            rsp_ff, rsp_in;
   segtr_pkg::rsp_type            eng_rsp;
   logic                          eng_done;
   logic                          eng_busy;

   assign count_x = LW'(count_ff);

   // zero counts as one, anything above the store size saturates
   always_comb begin
      count_in = csr_wr_en ? csr_wr_data : count_ff;
      if (count_x == '0) begin
         used_count = LW'(1);
      end else if (32'(count_x) > MAX_ELEMENTS) begin
         used_count = LW'(MAX_ELEMENTS);
      end else begin
         used_count = count_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= segtr_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_comb begin
      rsp_valid_in = eng_done;
      rsp_in       = eng_done ? eng_rsp : rsp_ff;
   end

   segtr_engine #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .LW           (LW)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .clear_req  (csr_wr_en),
      .used_count (used_count),
      .start      (start),
      .req        (req_payload),
      .busy       (eng_busy),
      .done       (eng_done),
      .rsp        (eng_rsp)
   );

   assign busy        = eng_busy;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
